[sv/assert_macros.svh]
// Assertion macros for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[sv/lsce_pkg.sv]
// Shared constants, types and helpers for the line sensor centroid block
`timescale 1ns / 1ps
package lsce_pkg;

    localparam int NUM_SENSORS    = 8;
    localparam int SENSOR_SPACING = 1000;
    localparam int SAMPLE_W       = 12;
    localparam int POS_W          = 13;
    localparam int ERR_W          = 14;
    localparam int GAIN_W         = 16;
    localparam int FRAC_W         = 16;
    localparam int CFG_W          = 16;

    // Derived widths of the centroid datapath
    localparam int MAX_WEIGHT = NUM_SENSORS * SENSOR_SPACING;
    localparam int WEIGHT_W   = $clog2(MAX_WEIGHT + 1);
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int TREE_W     = $clog2(NUM_SENSORS);
    localparam int TOTAL_W    = SAMPLE_W + TREE_W;
    localparam int SUM_W      = PROD_W + TREE_W;
    // Quotient never exceeds MAX_WEIGHT, so WEIGHT_W bits hold it
    localparam int QUO_W      = WEIGHT_W;
    localparam int CMP_W      = (QUO_W > POS_W) ? QUO_W : POS_W;

    localparam logic [POS_W-1:0]  POS_MAX      = '1;
    localparam logic [POS_W-1:0]  CENTER_RESET = POS_W'(4500);
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(3277);

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic [WEIGHT_W-1:0]      weight_t;
    typedef logic [PROD_W-1:0]        prod_t;
    typedef logic [TOTAL_W-1:0]       total_t;
    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [QUO_W-1:0]         quo_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic [GAIN_W-1:0]        gain_t;
    typedef logic [CFG_W-1:0]         cfg_data_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_CENTER_TARGET = 1'b0,
        CFG_GAIN_Q16      = 1'b1
    } cfg_reg_t;

    // Merged lane results handed to the divider
    typedef struct packed {
        sum_t   weighted;
        total_t total;
    } centroid_sum_t;

    // Position weight of lane idx (sensor idx+1)
    function automatic weight_t lane_weight(input int idx);
        return WEIGHT_W'((idx + 1) * SENSOR_SPACING);
    endfunction

endpackage

[sv/lsce_lane.sv]
// One sensor lane: baseline subtraction and position weighting
`timescale 1ns / 1ps
module lsce_lane (
    input  logic              clk,
    input  logic              en,
    input  lsce_pkg::sample_t sample,
    input  lsce_pkg::sample_t lowest,
    input  lsce_pkg::weight_t weight,
    output lsce_pkg::sample_t diff,
    output lsce_pkg::prod_t   prod
);
    import lsce_pkg::*;

    sample_t diff_next;
    sample_t diff_reg;
    prod_t   prod_next;
    prod_t   prod_reg;

    // Sample above frame minimum, then scaled by lane weight
    always_comb
    begin
        diff_next = sample - lowest;
        prod_next = prod_t'(diff_next) * prod_t'(weight);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
        end
    end

    assign diff = diff_reg;
    assign prod = prod_reg;

endmodule

[sv/lsce_merge.sv]
// Registered adder tree merging the eight lane results
`timescale 1ns / 1ps
module lsce_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lsce_pkg::prod_t         prod [lsce_pkg::NUM_SENSORS],
    input  lsce_pkg::sample_t       diff [lsce_pkg::NUM_SENSORS],
    output logic                    out_valid,
    input  logic                    out_ready,
    output lsce_pkg::centroid_sum_t sums
);
    import lsce_pkg::*;

    localparam int N1 = NUM_SENSORS / 2;
    localparam int N2 = N1 / 2;

    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          load1;
    logic          load2;
    logic          load3;
    sum_t          wsum1_reg [N1];
    total_t        tsum1_reg [N1];
    sum_t          wsum2_reg [N2];
    total_t        tsum2_reg [N2];
    centroid_sum_t sums_reg;

    // Each level loads when empty or when the next one takes its request
    assign load3    = !v3_reg || out_ready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign in_ready = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= in_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    // Pairwise sums: eight to four to two to one
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            for (int i = 0; i < N1; i++)
            begin
                wsum1_reg[i] <= sum_t'(prod[2*i]) + sum_t'(prod[2*i+1]);
                tsum1_reg[i] <= total_t'(diff[2*i]) + total_t'(diff[2*i+1]);
            end
        end
        if (load2)
        begin
            for (int i = 0; i < N2; i++)
            begin
                wsum2_reg[i] <= wsum1_reg[2*i] + wsum1_reg[2*i+1];
                tsum2_reg[i] <= tsum1_reg[2*i] + tsum1_reg[2*i+1];
            end
        end
        if (load3)
        begin
            sums_reg.weighted <= wsum2_reg[0] + wsum2_reg[1];
            sums_reg.total    <= tsum2_reg[0] + tsum2_reg[1];
        end
    end

    assign out_valid = v3_reg;
    assign sums      = sums_reg;

endmodule

[sv/lsce_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module lsce_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lsce_pkg::centroid_sum_t sums,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lsce_pkg::quo_t          quotient,
    output logic                    flat
);
    import lsce_pkg::*;

    localparam int STAGES = QUO_W;

    logic   valid_reg  [STAGES];
    logic   valid_in   [STAGES];
    logic   load       [STAGES];
    logic   next_ready [STAGES];
    sum_t   rem_reg    [STAGES];
    sum_t   rem_in     [STAGES];
    total_t den_reg    [STAGES];
    total_t den_in     [STAGES];
    quo_t   quo_reg    [STAGES];
    quo_t   quo_in     [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int BIT = STAGES - 1 - k;

        sum_t shifted;
        logic fits;

        // Stage inputs come from the port or from the previous stage
        if (k == 0)
        begin : g_first
            assign rem_in[k]   = sums.weighted;
            assign den_in[k]   = sums.total;
            assign quo_in[k]   = '0;
            assign valid_in[k] = in_valid;
        end
        else
        begin : g_next
            assign rem_in[k]   = rem_reg[k-1];
            assign den_in[k]   = den_reg[k-1];
            assign quo_in[k]   = quo_reg[k-1];
            assign valid_in[k] = valid_reg[k-1];
        end

        if (k == STAGES - 1)
        begin : g_last
            assign next_ready[k] = out_ready;
        end
        else
        begin : g_mid
            assign next_ready[k] = load[k+1];
        end

        assign load[k] = !valid_reg[k] || next_ready[k];

        // Trial subtract of the divisor aligned to this quotient bit
        assign shifted = sum_t'(den_in[k]) << BIT;
        assign fits    = rem_in[k] >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (load[k])
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (load[k])
            begin
                rem_reg[k] <= fits ? (rem_in[k] - shifted) : rem_in[k];
                den_reg[k] <= den_in[k];
                quo_reg[k] <= quo_in[k] | (fits ? (quo_t'(1) << BIT) : quo_t'(0));
            end
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = quo_reg[STAGES-1];
    // Zero divisor means every sample was equal
    assign flat      = (den_reg[STAGES-1] == '0);

endmodule

[sv/line_sensor_centroid_error_top.sv]
// Top level of the line sensor centroid and proportional error block
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per frame: eight
//   12-bit sensor samples. Output channel (out_valid/out_ready) returns one
//   result per frame: line position, position error, drive correction and
//   the flat-frame flag, in frame order.
//   A request passes through 1 min-finder register, 1 lane register,
//   3 adder-tree levels, 13 divider stages (one per quotient bit),
//   1 error stage and 1 gain-multiply/output register, which drives
//   out_valid. Throughput is one frame per cycle unless the receiver
//   stalls; every stage has its own valid and loads whenever it is empty
//   or its successor takes its request.
//   When the receiver stalls, the result holds in the output register and
//   requests keep entering until the pipeline is full of waiting frames.
//   Reset clears all valids and loads center_target = 4500 and
//   gain_q16 = 3277. Config writes (cfg_we, cfg_index, cfg_data) take
//   effect at once and are meant for an idle pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module line_sensor_centroid_error_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lsce_pkg::sample_t   sample_one,
    input  lsce_pkg::sample_t   sample_two,
    input  lsce_pkg::sample_t   sample_three,
    input  lsce_pkg::sample_t   sample_four,
    input  lsce_pkg::sample_t   sample_five,
    input  lsce_pkg::sample_t   sample_six,
    input  lsce_pkg::sample_t   sample_seven,
    input  lsce_pkg::sample_t   sample_eight,
    output logic                out_valid,
    input  logic                out_ready,
    output lsce_pkg::pos_t      line_position,
    output lsce_pkg::err_t      position_error,
    output lsce_pkg::err_t      drive_correction,
    output logic                flat_frame,
    input  logic                cfg_we,
    input  lsce_pkg::cfg_reg_t  cfg_index,
    input  lsce_pkg::cfg_data_t cfg_data
);
    import lsce_pkg::*;

    localparam int DPROD_W = POS_W + GAIN_W;

    // Configuration
    pos_t          center_target_reg;
    gain_t         gain_q16_reg;

    // Front stage
    sample_t       samples [NUM_SENSORS];
    sample_t       lowest_next;
    sample_t       samp_reg [NUM_SENSORS];
    sample_t       lowest_reg;
    logic          s1_valid_reg;
    logic          load_s1;

    // Lane stage
    logic          s2_valid_reg;
    logic          load_s2;
    sample_t       lane_diff [NUM_SENSORS];
    prod_t         lane_prod [NUM_SENSORS];

    // Merge and divide
    logic          merge_ready;
    logic          merge_valid;
    centroid_sum_t merge_sums;
    logic          div_ready;
    logic          div_valid;
    quo_t          div_quo;
    logic          div_flat;

    // Error stage
    logic          p1_valid_reg;
    logic          load_p1;
    logic [CMP_W-1:0] q_ext;
    pos_t          sat_pos;
    pos_t          pos_next;
    err_t          err_next;
    pos_t          mag_next;
    pos_t          p1_pos_reg;
    err_t          p1_err_reg;
    pos_t          p1_mag_reg;
    logic          p1_flat_reg;

    // Drive and output stage
    logic          load_p2;
    logic [DPROD_W-1:0] drive_prod;
    pos_t          drive_mag;
    err_t          drive_abs;
    err_t          drive_next;
    logic          out_valid_reg;
    pos_t          line_position_reg;
    err_t          position_error_reg;
    err_t          drive_correction_reg;
    logic          flat_frame_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_target_reg <= CENTER_RESET;
            gain_q16_reg      <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_TARGET: center_target_reg <= POS_W'(cfg_data);
                CFG_GAIN_Q16:      gain_q16_reg      <= GAIN_W'(cfg_data);
                default:           center_target_reg <= center_target_reg;
            endcase
        end
    end

    assign samples[0] = sample_one;
    assign samples[1] = sample_two;
    assign samples[2] = sample_three;
    assign samples[3] = sample_four;
    assign samples[4] = sample_five;
    assign samples[5] = sample_six;
    assign samples[6] = sample_seven;
    assign samples[7] = sample_eight;

    // Frame minimum
    always_comb
    begin
        lowest_next = samples[0];
        for (int i = 1; i < NUM_SENSORS; i++)
        begin
            if (samples[i] < lowest_next)
                lowest_next = samples[i];
        end
    end

    // Pipeline enables
    assign load_p2 = !out_valid_reg || out_ready;
    assign load_p1 = !p1_valid_reg || load_p2;
    assign load_s2 = !s2_valid_reg || merge_ready;
    assign load_s1 = !s1_valid_reg || load_s2;
    assign in_ready = load_s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
                s1_valid_reg <= in_valid;
            if (load_s2)
                s2_valid_reg <= s1_valid_reg;
            if (load_p1)
                p1_valid_reg <= div_valid;
            if (load_p2)
                out_valid_reg <= p1_valid_reg;
        end
    end

    // Front register: samples and their minimum
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
                samp_reg[i] <= samples[i];
            lowest_reg <= lowest_next;
        end
    end

    // Parallel sensor lanes
    for (genvar i = 0; i < NUM_SENSORS; i++)
    begin : g_lane
        lsce_lane u_lane (
            .clk    (clk),
            .en     (load_s2),
            .sample (samp_reg[i]),
            .lowest (lowest_reg),
            .weight (lane_weight(i)),
            .diff   (lane_diff[i]),
            .prod   (lane_prod[i])
        );
    end

    lsce_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_ready  (merge_ready),
        .prod      (lane_prod),
        .diff      (lane_diff),
        .out_valid (merge_valid),
        .out_ready (div_ready),
        .sums      (merge_sums)
    );

    lsce_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (merge_valid),
        .in_ready  (div_ready),
        .sums      (merge_sums),
        .out_valid (div_valid),
        .out_ready (load_p1),
        .quotient  (div_quo),
        .flat      (div_flat)
    );

    // Saturate centroid, substitute center on a flat frame, form error
    always_comb
    begin
        q_ext    = CMP_W'(div_quo);
        sat_pos  = (q_ext > CMP_W'(POS_MAX)) ? POS_MAX : POS_W'(q_ext);
        pos_next = div_flat ? center_target_reg : sat_pos;
        err_next = $signed(ERR_W'(center_target_reg) - ERR_W'(pos_next));
        mag_next = err_next[ERR_W-1] ? POS_W'(-err_next) : POS_W'(err_next);
    end

    always_ff @(posedge clk)
    begin
        if (load_p1)
        begin
            p1_pos_reg  <= pos_next;
            p1_err_reg  <= err_next;
            p1_mag_reg  <= mag_next;
            p1_flat_reg <= div_flat;
        end
    end

    // Gain applied to the error magnitude, sign restored afterwards
    always_comb
    begin
        drive_prod = DPROD_W'(p1_mag_reg) * DPROD_W'(gain_q16_reg);
        drive_mag  = POS_W'(drive_prod >> FRAC_W);
        drive_abs  = $signed(ERR_W'(drive_mag));
        drive_next = p1_err_reg[ERR_W-1] ? -drive_abs : drive_abs;
    end

    always_ff @(posedge clk)
    begin
        if (load_p2)
        begin
            line_position_reg    <= p1_pos_reg;
            position_error_reg   <= p1_err_reg;
            drive_correction_reg <= drive_next;
            flat_frame_reg       <= p1_flat_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign line_position    = line_position_reg;
    assign position_error   = position_error_reg;
    assign drive_correction = drive_correction_reg;
    assign flat_frame       = flat_frame_reg;

    // Checks
    `ASSERT_CLK(a_flat_zero, clk, rst_n, out_valid_reg && flat_frame_reg |-> position_error_reg == '0 && drive_correction_reg == '0)
    `ASSERT_CLK(a_err_consistent, clk, rst_n, out_valid_reg |-> position_error_reg == $signed(ERR_W'(center_target_reg) - ERR_W'(line_position_reg)))
    `ASSERT_NEVER(a_drive_sign, clk, rst_n, out_valid_reg && drive_correction_reg[ERR_W-1] && !position_error_reg[ERR_W-1])
    `ASSERT_CLK(a_front_hold, clk, rst_n, s1_valid_reg && !load_s2 |=> s1_valid_reg && $stable(lowest_reg))

endmodule

[bench/tb_line_sensor_centroid_error_top.sv]
// Testbench for the line sensor centroid and proportional error block
`timescale 1ns / 1ps
module tb_line_sensor_centroid_error_top;
    import lsce_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int PIPE_LATENCY = 20;
    localparam int IDLE_LIMIT   = 4000;

    typedef sample_t [NUM_SENSORS-1:0] frame_t;

    // One expected steering result
    typedef struct packed {
        pos_t position;
        err_t error;
        err_t drive;
        logic flat;
    } steer_result_t;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_LONG_STALL
    } rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    frame_t      samples;
    logic        out_valid;
    logic        out_ready;
    pos_t        line_position;
    err_t        position_error;
    err_t        drive_correction;
    logic        flat_frame;
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    cfg_data_t   cfg_data;

    // Predictor copy of the configuration registers
    pos_t  model_center = CENTER_RESET;
    gain_t model_gain   = GAIN_RESET;

    steer_result_t pending_results[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            burst_left  = 1;

    line_sensor_centroid_error_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample_one       (samples[0]),
        .sample_two       (samples[1]),
        .sample_three     (samples[2]),
        .sample_four      (samples[3]),
        .sample_five      (samples[4]),
        .sample_six       (samples[5]),
        .sample_seven     (samples[6]),
        .sample_eight     (samples[7]),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .line_position    (line_position),
        .position_error   (position_error),
        .drive_correction (drive_correction),
        .flat_frame       (flat_frame),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Centroid, error and drive for one frame under the current settings
    function automatic steer_result_t centroid_result(input frame_t f);
        steer_result_t   r;
        sample_t         lowest;
        longint unsigned weighted;
        longint unsigned total;
        longint unsigned quotient;
        longint          center;
        longint          pos;
        longint          gain;
        longint          err;
        longint          drive;
        lowest = f[0];
        for (int i = 1; i < NUM_SENSORS; i++)
        begin
            if (f[i] < lowest)
                lowest = f[i];
        end
        weighted = 0;
        total    = 0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            total    += longint'(f[i] - lowest);
            weighted += longint'(i + 1) * SENSOR_SPACING * longint'(f[i] - lowest);
        end
        if (total == 0)
        begin
            // flat frame: no divisor, report the target itself
            r.position = model_center;
            r.error    = '0;
            r.drive    = '0;
            r.flat     = 1'b1;
            return r;
        end
        quotient   = weighted / total;
        r.position = (quotient > POS_MAX) ? POS_MAX : pos_t'(quotient);
        center     = model_center;
        pos        = r.position;
        gain       = model_gain;
        err        = center - pos;
        // drive is built on the magnitude so it truncates toward zero
        if (err < 0)
            drive = -(((-err) * gain) >>> FRAC_W);
        else
            drive = (err * gain) >>> FRAC_W;
        r.error = ERR_W'(err);
        r.drive = ERR_W'(drive);
        r.flat  = 1'b0;
        return r;
    endfunction

    function automatic frame_t one_hot(input int idx);
        frame_t f;
        f      = '0;
        f[idx] = '1;
        return f;
    endfunction

    // Mostly line-over-background frames, plus two-level, flat, near-flat and noise
    function automatic frame_t random_frame();
        frame_t f;
        int     kind;
        int     bg_level;
        int     line_level;
        int     span;
        int     left;
        int     idx;
        kind = $urandom_range(0, 9);
        if (kind <= 4)
        begin
            bg_level   = $urandom_range(0, 4095);
            line_level = $urandom_range(0, 4095);
            span       = $urandom_range(1, 3);
            left       = $urandom_range(0, NUM_SENSORS - span);
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (i >= left && i < left + span)
                    f[i] = sample_t'(line_level);
                else
                    f[i] = sample_t'(bg_level ^ $urandom_range(0, 31));
            end
        end
        else if (kind <= 6)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
                f[i] = sample_t'($urandom_range(0, 4095));
        end
        else if (kind == 7)
        begin
            f = {NUM_SENSORS{sample_t'($urandom_range(0, 4095))}};
        end
        else if (kind == 8)
        begin
            bg_level   = $urandom_range(0, 4095);
            line_level = $urandom_range(0, 4095);
            for (int i = 0; i < NUM_SENSORS; i++)
                f[i] = sample_t'(($urandom_range(0, 1) == 1) ? line_level : bg_level);
        end
        else
        begin
            // one sensor a single count away from the rest
            bg_level = $urandom_range(1, 4094);
            idx      = $urandom_range(0, NUM_SENSORS - 1);
            f        = {NUM_SENSORS{sample_t'(bg_level)}};
            f[idx]   = sample_t'(($urandom_range(0, 1) == 1) ? bg_level + 1 : bg_level - 1);
        end
        return f;
    endfunction

    // Send one frame request; valid stays high only while a burst lasts
    task automatic send_frame(input frame_t f);
        samples  = f;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(centroid_result(f));
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 4)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_config(input pos_t center, input gain_t gain);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = CFG_CENTER_TARGET;
        cfg_data  = cfg_data_t'(center);
        @(negedge clk);
        cfg_index = CFG_GAIN_Q16;
        cfg_data  = gain;
        @(negedge clk);
        cfg_we       = 1'b0;
        model_center = center;
        model_gain   = gain;
    endtask

    // Reset values of target and gain, seen through flat and edge frames
    task automatic test_reset_defaults();
        send_frame('0);
        send_frame(one_hot(NUM_SENSORS - 1));
        send_frame(one_hot(0));
    endtask

    // Centroid over flat, single-sensor and spread shapes
    task automatic test_centroid_shapes();
        frame_t f;
        send_frame('1);
        for (int i = 1; i < NUM_SENSORS - 1; i++)
            send_frame(one_hot(i));
        f    = '1;
        f[0] = '0;
        send_frame(f);
        for (int i = 0; i < NUM_SENSORS; i++)
            f[i] = (i % 2 == 1) ? '1 : '0;
        send_frame(f);
        for (int i = 0; i < NUM_SENSORS; i++)
            f[i] = sample_t'(i * 585);
        send_frame(f);
        f    = {NUM_SENSORS{sample_t'(2048)}};
        f[4] = sample_t'(2049);
        send_frame(f);
    endtask

    // Target and gain at their limits, both error signs
    task automatic test_gain_extremes();
        frame_t f;
        write_config(pos_t'(8000), gain_t'(65535));
        send_frame(one_hot(0));
        send_frame({NUM_SENSORS{sample_t'(77)}});
        write_config(pos_t'(0), gain_t'(65535));
        send_frame(one_hot(NUM_SENSORS - 1));
        send_frame('0);
        f    = {NUM_SENSORS{sample_t'(3000)}};
        f[2] = sample_t'(2999);
        send_frame(f);
        write_config(pos_t'(0), gain_t'(0));
        send_frame(one_hot(3));
        write_config(pos_t'(8000), gain_t'(1));
        send_frame(one_hot(0));
    endtask

    // Random frames over several settings, with one full drain mid-phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: write_config(pos_t'(8000), gain_t'(65535));
                2: write_config(pos_t'(0), gain_t'(0));
                4: write_config(CENTER_RESET, GAIN_RESET);
                5: write_config(pos_t'(0), gain_t'(65535));
                default: write_config(pos_t'($urandom_range(0, 8000)),
                                      gain_t'($urandom_range(0, 65535)));
            endcase
            for (int n = 0; n < 170; n++)
            begin
                if (phase == 2 && n == 85)
                    wait_drained();
                send_frame(random_frame());
            end
        end
    endtask

    // Receiver back-pressure, switching at random among four styles
    initial
    begin : receiver_pattern
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        int       period;
        int       low_len;
        int       phase_cnt;
        out_ready  = 1'b0;
        mode       = RX_OPEN;
        mode_left  = 0;
        stall_left = 0;
        period     = 2;
        low_len    = 1;
        phase_cnt  = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
                period    = $urandom_range(2, 12);
                low_len   = $urandom_range(1, period - 1);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                RX_OPEN:     out_ready = 1'b1;
                RX_COIN:     out_ready = ($urandom_range(0, 1) == 1);
                RX_PERIODIC: out_ready = ((phase_cnt % period) >= low_len);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        out_ready = 1'b0;
                        stall_left--;
                    end
                    else
                    begin
                        out_ready = 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 40);
                    end
                end
            endcase
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        steer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: line_position %0d", line_position);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (line_position !== want.position)
                begin
                    $error("line_position expected %0d got %0d", want.position, line_position);
                    error_count++;
                end
                if (position_error !== want.error)
                begin
                    $error("position_error expected %0d got %0d", want.error, position_error);
                    error_count++;
                end
                if (drive_correction !== want.drive)
                begin
                    $error("drive_correction expected %0d got %0d",
                           want.drive, drive_correction);
                    error_count++;
                end
                if (flat_frame !== want.flat)
                begin
                    $error("flat_frame expected %0b got %0b", want.flat, flat_frame);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither channel moves a request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("line_sensor_centroid_error_top test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        samples   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CENTER_TARGET;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_centroid_shapes();
        test_gain_extremes();
        test_random_traffic();

        wait_drained();
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("line_sensor_centroid_error_top test passed");
        else
            $display("line_sensor_centroid_error_top test failed");
        $finish;
    end

endmodule

[line_sensor_centroid_error_top.f]
+incdir+sv
sv/lsce_pkg.sv
sv/lsce_lane.sv
sv/lsce_merge.sv
sv/lsce_div.sv
sv/line_sensor_centroid_error_top.sv
bench/tb_line_sensor_centroid_error_top.sv
